// File: design/quantized_channel_scale_top_macros.svh
// Assertion macros shared by the quantized channel scale design files.
// Every macro assumes a clock named clk and a synchronous reset named rst in scope.
`ifndef QUANTIZED_CHANNEL_SCALE_TOP_MACROS_SVH
`define QUANTIZED_CHANNEL_SCALE_TOP_MACROS_SVH

// Same-cycle implication.
`define QCS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/qcs_pkg.sv
// Shared types and constants for the quantized channel scale block.
// No dependencies; used by every other design file but the macro header.
package qcs_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_ZERO      = 3'd0,
    REG_SRC_SCALE     = 3'd1,
    REG_DST_INV_SCALE = 3'd2,
    REG_DST_ZERO      = 3'd3,
    REG_LAYOUT        = 3'd4,
    REG_CHANNEL_COUNT = 3'd5,
    REG_PLANE_SIZE    = 3'd6
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int CH_W       = 10;
  localparam int CH_LIMIT   = 1024;
  localparam int PL_W       = 20;
  localparam int PLANE_MAX  = 1048576;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] SCALE_ONE = 32'h0100_0000;  // 1.0 in Q8.24

  typedef struct packed {
    logic [7:0]  src_zero;
    logic [31:0] src_scale;
    logic [31:0] dst_inv_scale;
    logic [7:0]  dst_zero;
    logic        layout;
    logic [10:0] channel_count;
    logic [20:0] plane_size;
  } cfg_t;

  // One sample handed from the front end to the arithmetic back end
  typedef struct packed {
    logic [7:0]      sample;
    logic [CH_W-1:0] ch;
    logic            tensor_end;
    logic [31:0]     scale;
    logic [31:0]     bias;
  } qcs_item_t;

endpackage

// File: design/qcs_fifo.sv
// Short queue of classified samples between front end and back end.
// Depends on qcs_pkg and the assertion macro header.
`include "quantized_channel_scale_top_macros.svh"

module qcs_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  qcs_pkg::qcs_item_t        push_item,
  input  logic                      pop,
  output qcs_pkg::qcs_item_t        head,
  output logic                      empty,
  output logic [qcs_pkg::QCNT_W-1:0] level
);

  qcs_pkg::qcs_item_t             entries [qcs_pkg::QUEUE_DEPTH];
  logic [qcs_pkg::QPTR_W-1:0]     wr_ptr;
  logic [qcs_pkg::QPTR_W-1:0]     rd_ptr;

  assign head  = entries[rd_ptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  `QCS_ASSERT_IMPL(a_no_overflow, push, level < qcs_pkg::QCNT_W'(qcs_pkg::QUEUE_DEPTH), "queue overflow")
  `QCS_ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// File: design/qcs_front.sv
// Front end: input handshake, opcode decode, coefficient memory, position counters.
// Depends on qcs_pkg and the assertion macro header; feeds qcs_fifo.
`include "quantized_channel_scale_top_macros.svh"

module qcs_front #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  qcs_pkg::cfg_t              cfg,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [87:0]                s_tdata,
  input  logic                       s_tuser,
  input  logic [qcs_pkg::QCNT_W-1:0] level,
  output logic                       push,
  output qcs_pkg::qcs_item_t         push_item
);

  localparam int AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_MAX = (MAX_CHANNELS < qcs_pkg::CH_LIMIT) ? MAX_CHANNELS
                                                               : qcs_pkg::CH_LIMIT;
  localparam int LW      = qcs_pkg::QCNT_W + 1;

  // tdata fields
  logic [9:0]  coef_channel;
  logic [31:0] coef_scale;
  logic [31:0] coef_bias;
  logic [7:0]  sample;
  logic        restart;

  assign coef_channel = s_tdata[9:0];
  assign coef_scale   = s_tdata[41:10];
  assign coef_bias    = s_tdata[73:42];
  assign sample       = s_tdata[81:74];
  assign restart      = s_tdata[82];

  qcs_pkg::opcode_t op;
  logic             accept;
  logic             do_load;
  logic             do_sample;

  assign op        = qcs_pkg::opcode_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;
  assign do_load   = accept && (op == qcs_pkg::OP_LOAD) &&
                     (32'(coef_channel) < MAX_CHANNELS);
  assign do_sample = accept && (op == qcs_pkg::OP_SAMPLE);

  // Stage register between accept and queue push
  logic                     s1_valid;
  logic [7:0]               s1_sample;
  logic [qcs_pkg::CH_W-1:0] s1_ch;
  logic                     s1_end;
  logic [63:0]              s1_coef;

  // Hold back in reset and unless the queue has room for the item already in flight too
  assign s_tready = !rst &&
                    ((LW'(level) + LW'(s1_valid)) < LW'(qcs_pkg::QUEUE_DEPTH));

  // Position counters
  logic [qcs_pkg::CH_W-1:0] channel_position, channel_position_next;
  logic [qcs_pkg::PL_W-1:0] plane_position, plane_position_next;
  logic [qcs_pkg::CH_W-1:0] ch_cur;
  logic [qcs_pkg::PL_W-1:0] pl_cur;
  logic [10:0]              nch;
  logic [20:0]              npl;
  logic                     last_ch;
  logic                     last_pl;

  always_comb begin
    if (cfg.channel_count > 11'(NCH_MAX))   nch = 11'(NCH_MAX);
    else if (cfg.channel_count == '0)       nch = 11'd1;
    else                                    nch = cfg.channel_count;
    if (cfg.plane_size > 21'(qcs_pkg::PLANE_MAX)) npl = 21'(qcs_pkg::PLANE_MAX);
    else if (cfg.plane_size == '0)                npl = 21'd1;
    else                                          npl = cfg.plane_size;
  end

  assign ch_cur  = restart ? '0 : channel_position;
  assign pl_cur  = restart ? '0 : plane_position;
  assign last_ch = (11'(ch_cur) + 11'd1) >= nch;
  assign last_pl = (21'(pl_cur) + 21'd1) >= npl;

  always_comb begin
    channel_position_next = channel_position;
    plane_position_next   = plane_position;
    if (do_sample) begin
      if (cfg.layout) begin
        // interleaved: channel runs fastest
        if (last_ch) begin
          channel_position_next = '0;
          plane_position_next   = last_pl ? '0 : pl_cur + 1'b1;
        end else begin
          channel_position_next = ch_cur + 1'b1;
          plane_position_next   = pl_cur;
        end
      end else begin
        // channel-major: position runs fastest
        if (last_pl) begin
          plane_position_next   = '0;
          channel_position_next = last_ch ? '0 : ch_cur + 1'b1;
        end else begin
          plane_position_next   = pl_cur + 1'b1;
          channel_position_next = ch_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_position <= '0;
      plane_position   <= '0;
      s1_valid         <= 1'b0;
    end else begin
      channel_position <= channel_position_next;
      plane_position   <= plane_position_next;
      s1_valid         <= do_sample;
    end
  end

  // Coefficient memory: {scale, bias} per channel, one write and one read port
  logic [63:0] coef_mem [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (do_load) coef_mem[AW'(coef_channel)] <= {coef_scale, coef_bias};
    if (do_sample) begin
      s1_coef   <= coef_mem[AW'(ch_cur)];
      s1_sample <= sample;
      s1_ch     <= ch_cur;
      s1_end    <= last_ch && last_pl;
    end
  end

  assign push                 = s1_valid;
  assign push_item.sample     = s1_sample;
  assign push_item.ch         = s1_ch;
  assign push_item.tensor_end = s1_end;
  assign push_item.scale      = s1_coef[63:32];
  assign push_item.bias       = s1_coef[31:0];

  `QCS_ASSERT_IMPL(a_wrap_on_end, s1_valid && s1_end, channel_position == '0 && plane_position == '0, "counters did not wrap at tensor end")

endmodule

// File: design/qcs_back.sv
// Back end: pipelined fixed point requantize, round half to even, saturate.
// Depends on qcs_pkg and the assertion macro header; drains qcs_fifo.
`include "quantized_channel_scale_top_macros.svh"

module qcs_back (
  input  logic               clk,
  input  logic               rst,
  input  qcs_pkg::cfg_t      cfg,
  input  qcs_pkg::qcs_item_t head,
  input  logic               empty,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  localparam int NSTG = 9;   // stage 9 is the output register
  localparam int P_W  = 72;  // |product|, Q.48
  localparam int V_W  = 74;  // signed sum with bias
  localparam int MV_W = 73;  // |sum|
  localparam int M_W  = 105; // |sum| * reciprocal, Q.72

  typedef struct packed {
    logic [qcs_pkg::CH_W-1:0] ch;
    logic                     tensor_end;
  } tag_t;

  logic            adv;
  logic [NSTG-1:0] vld;
  tag_t            tag [NSTG];

  assign adv = !vld[NSTG-1] || m_tready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= '{ch: head.ch, tensor_end: head.tensor_end};
      for (int i = 1; i < NSTG; i++) tag[i] <= tag[i-1];
    end
  end

  // Stage 1: sign/magnitude of both factors, (x - zero) * src_scale
  logic        neg_d, neg_c;
  logic [7:0]  mag_d;
  logic [31:0] mag_c;

  assign neg_d = head.sample < cfg.src_zero;
  assign mag_d = neg_d ? (cfg.src_zero - head.sample) : (head.sample - cfg.src_zero);
  assign neg_c = head.scale[31];
  assign mag_c = neg_c ? (32'd0 - head.scale) : head.scale;

  logic        s1_neg;
  logic [39:0] s1_pd;
  logic [31:0] s1_mag_c;
  logic [31:0] s1_bias;

  // Stage 2: pd * mag_c split into two partial products
  logic        s2_neg;
  logic [63:0] s2_pp0;
  logic [39:0] s2_pp1;
  logic [31:0] s2_bias;

  // Stage 3: product assembled
  logic           s3_neg;
  logic [P_W-1:0] s3_p;
  logic [31:0]    s3_bias;

  // Stage 4: signed sum with bias moved to Q.48
  logic [V_W-1:0] s4_v;
  logic [V_W-1:0] p_ext;
  logic [V_W-1:0] bias_ext;

  assign p_ext    = V_W'(s3_p) ^ {V_W{s3_neg}};
  assign bias_ext = {{(V_W - 64){s3_bias[31]}}, s3_bias, 32'd0};

  // Stage 5: magnitude of the sum
  logic            s5_neg;
  logic [MV_W-1:0] s5_mag;
  logic [V_W-1:0]  v_abs;

  assign v_abs = s4_v[V_W-1] ? (V_W'(0) - s4_v) : s4_v;

  // Stage 6: |sum| * dst_inv_scale in three partial products
  logic        s6_neg;
  logic [63:0] s6_pm0;
  logic [63:0] s6_pm1;
  logic [40:0] s6_pm2;

  // Stage 7: full Q.72 magnitude
  logic           s7_neg;
  logic [M_W-1:0] s7_m;

  // Stage 8: round half to even at bit 72
  logic        s8_neg;
  logic [33:0] s8_q;
  logic [32:0] q_trunc;
  logic        round_up;

  assign q_trunc  = s7_m[M_W-1:72];
  assign round_up = s7_m[71] && ((|s7_m[70:0]) || q_trunc[0]);

  // Stage 9: add output zero point and saturate
  logic [35:0] r;
  logic [7:0]  out_value;
  logic        out_clamped;

  assign r = s8_neg ? (36'(cfg.dst_zero) - 36'(s8_q)) : (36'(cfg.dst_zero) + 36'(s8_q));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg   <= neg_d ^ neg_c;
      s1_pd    <= 40'(mag_d) * 40'(cfg.src_scale);
      s1_mag_c <= mag_c;
      s1_bias  <= head.bias;

      s2_neg   <= s1_neg;
      s2_pp0   <= 64'(s1_pd[31:0]) * 64'(s1_mag_c);
      s2_pp1   <= 40'(s1_pd[39:32]) * 40'(s1_mag_c);
      s2_bias  <= s1_bias;

      s3_neg   <= s2_neg;
      s3_p     <= P_W'(s2_pp0) + {s2_pp1, 32'd0};
      s3_bias  <= s2_bias;

      s4_v     <= bias_ext + p_ext + V_W'(s3_neg);

      s5_neg   <= s4_v[V_W-1];
      s5_mag   <= v_abs[MV_W-1:0];

      s6_neg   <= s5_neg;
      s6_pm0   <= 64'(s5_mag[31:0]) * 64'(cfg.dst_inv_scale);
      s6_pm1   <= 64'(s5_mag[63:32]) * 64'(cfg.dst_inv_scale);
      s6_pm2   <= 41'(s5_mag[72:64]) * 41'(cfg.dst_inv_scale);

      s7_neg   <= s6_neg;
      s7_m     <= M_W'(s6_pm0) + M_W'({s6_pm1, 32'd0}) + {s6_pm2, 64'd0};

      s8_neg   <= s7_neg;
      s8_q     <= 34'(q_trunc) + 34'(round_up);

      if (r[35]) begin
        out_value   <= 8'd0;
        out_clamped <= 1'b1;
      end else if (|r[34:8]) begin
        out_value   <= 8'hFF;
        out_clamped <= 1'b1;
      end else begin
        out_value   <= r[7:0];
        out_clamped <= 1'b0;
      end
    end
  end

  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = {6'd0, tag[NSTG-1].ch, out_value};
  assign m_tuser  = out_clamped;
  assign m_tlast  = tag[NSTG-1].tensor_end;

  `QCS_ASSERT_IMPL(a_clamp_at_rails, m_tvalid && m_tuser, m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'hFF, "clamped flag on a value inside the range")
  `QCS_ASSERT_NEXT(a_stall_holds_pipe, m_tvalid && !m_tready, vld == $past(vld), "pipeline moved while output stalled")

endmodule

// File: design/quantized_channel_scale_top.sv
// Quantized channel scale: a stream of uint8 activations is requantized per channel,
// y = ((x - src_zero) * src_scale * scale[c] + bias[c]) * dst_inv_scale, rounded half to
// even, plus dst_zero, saturated to 0..255 with a clamp flag. Each input transfer is
// either a coefficient load (tuser 0), which writes scale and bias of one channel and
// yields nothing, or a sample (tuser 1), which yields exactly one output transfer in
// order. The channel of a sample comes from a position counter pair, channel-major or
// interleaved per the layout register; restart zeroes it before the sample. Load every
// channel in use before sending samples for it: coefficient memory has no reset. A new
// transfer is taken every cycle while the output keeps up; the rate is set by the single
// coefficient memory read per cycle in the front end and by the fully pipelined back end.
// With the queue empty, a sample goes this way before m_tvalid rises: the coefficient
// read happens at the accepting edge, the stage register moves the item into the
// four-entry queue, and the back-end pipeline carries it through the multiplier,
// rounding and output stages. Config is written through cfg_we/cfg_index/cfg_wdata and
// must only be changed while the block is idle.
// Built from qcs_front, qcs_fifo and qcs_back; types from qcs_pkg.

module quantized_channel_scale_top #(
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic [qcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // low to high: coef_channel[9:0], coef_scale[41:10], coef_bias[73:42],
  // sample[81:74], restart[82], zero [87:83]
  input  logic [87:0]                   s_tdata,
  // opcode: 0 coefficient load, 1 sample
  input  logic                          s_tuser,
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // low to high: out_value[7:0], out_channel[17:8], zero [23:18]
  output logic [23:0]                   m_tdata,
  // clamped
  output logic                          m_tuser,
  // tensor_end
  output logic                          m_tlast
);

  // Configuration registers
  qcs_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_zero      <= 8'd0;
      cfg.src_scale     <= qcs_pkg::SCALE_ONE;
      cfg.dst_inv_scale <= qcs_pkg::SCALE_ONE;
      cfg.dst_zero      <= 8'd0;
      cfg.layout        <= 1'b0;
      cfg.channel_count <= 11'd1;
      cfg.plane_size    <= 21'd1;
    end else if (cfg_we) begin
      unique case (qcs_pkg::cfg_reg_t'(cfg_index))
        qcs_pkg::REG_SRC_ZERO:      cfg.src_zero      <= cfg_wdata[7:0];
        qcs_pkg::REG_SRC_SCALE:     cfg.src_scale     <= cfg_wdata;
        qcs_pkg::REG_DST_INV_SCALE: cfg.dst_inv_scale <= cfg_wdata;
        qcs_pkg::REG_DST_ZERO:      cfg.dst_zero      <= cfg_wdata[7:0];
        qcs_pkg::REG_LAYOUT:        cfg.layout        <= cfg_wdata[0];
        qcs_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_wdata[10:0];
        qcs_pkg::REG_PLANE_SIZE:    cfg.plane_size    <= cfg_wdata[20:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Front end -> queue -> back end
  logic                       push;
  qcs_pkg::qcs_item_t         push_item;
  logic                       pop;
  qcs_pkg::qcs_item_t         head;
  logic                       empty;
  logic [qcs_pkg::QCNT_W-1:0] level;

  qcs_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .level     (level),
    .push      (push),
    .push_item (push_item)
  );

  qcs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .level     (level)
  );

  qcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
